// ===== src/tkc_pkg.sv =====
// Shared types and constants for the terminal key cursor tracker.
// Holds key codes, parser phase codes, byte constants and the structs that
// pass between the decoder, the motion logic and the top level.
package tkc_pkg;

   // Configuration register widths
   localparam int unsigned ROW_W  = 16;
   localparam int unsigned COL_W  = 12;
   localparam int unsigned SCR_W  = 12;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_COLS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILE_ROWS   = 2'd2;

   // Configuration reset values
   localparam logic [SCR_W-1:0] SCREEN_ROWS_RST = 12'd24;
   localparam logic [SCR_W-1:0] SCREEN_COLS_RST = 12'd80;
   localparam logic [ROW_W-1:0] FILE_ROWS_RST   = 16'd0;

   // Key codes
   localparam logic [3:0] KEY_NONE  = 4'd0;
   localparam logic [3:0] KEY_PLAIN = 4'd1;
   localparam logic [3:0] KEY_ESC   = 4'd2;
   localparam logic [3:0] KEY_UP    = 4'd3;
   localparam logic [3:0] KEY_DOWN  = 4'd4;
   localparam logic [3:0] KEY_LEFT  = 4'd5;
   localparam logic [3:0] KEY_RIGHT = 4'd6;
   localparam logic [3:0] KEY_HOME  = 4'd7;
   localparam logic [3:0] KEY_END   = 4'd8;
   localparam logic [3:0] KEY_PGUP  = 4'd9;
   localparam logic [3:0] KEY_PGDN  = 4'd10;
   localparam logic [3:0] KEY_DEL   = 4'd11;
   localparam logic [3:0] KEY_QUIT  = 4'd12;

   // Escape parser phases
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_ESC     = 3'd1;
   localparam logic [2:0] PH_BRACKET = 3'd2;
   localparam logic [2:0] PH_OH      = 3'd3;
   localparam logic [2:0] PH_OTHER   = 3'd4;
   localparam logic [2:0] PH_DIGIT   = 3'd5;

   // Input mode
   localparam logic MODE_BYTE    = 1'b0;
   localparam logic MODE_TIMEOUT = 1'b1;

   // Byte constants
   localparam logic [7:0] CH_ESC      = 8'h1b;
   localparam logic [7:0] CH_LBRACKET = 8'h5b;
   localparam logic [7:0] CH_UPPER_O  = 8'h4f;
   localparam logic [7:0] CH_TILDE    = 8'h7e;
   localparam logic [7:0] CH_CTRL_Q   = 8'h71 & 8'h1f;
   localparam logic [7:0] CH_A        = 8'h41;
   localparam logic [7:0] CH_B        = 8'h42;
   localparam logic [7:0] CH_C        = 8'h43;
   localparam logic [7:0] CH_D        = 8'h44;
   localparam logic [7:0] CH_F        = 8'h46;
   localparam logic [7:0] CH_H        = 8'h48;
   localparam logic [7:0] CH_0        = 8'h30;
   localparam logic [7:0] CH_1        = 8'h31;
   localparam logic [7:0] CH_3        = 8'h33;
   localparam logic [7:0] CH_4        = 8'h34;
   localparam logic [7:0] CH_5        = 8'h35;
   localparam logic [7:0] CH_6        = 8'h36;
   localparam logic [7:0] CH_7        = 8'h37;
   localparam logic [7:0] CH_8        = 8'h38;
   localparam logic [7:0] CH_9        = 8'h39;

   // Decoder verdict and parser next state
   typedef struct packed {
      logic [3:0] key;
      logic [2:0] phase;
      logic [7:0] digit;
   } dec_result_type;

   // Cursor and view position
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [ROW_W-1:0] row_off;
      logic [COL_W-1:0] col_off;
   } pos_type;

   // Window geometry
   typedef struct packed {
      logic [SCR_W-1:0] screen_rows;
      logic [SCR_W-1:0] screen_cols;
      logic [ROW_W-1:0] file_rows;
   } geom_type;

endpackage

// ===== src/tkc_req_if.sv =====
// Request channel of the terminal key cursor tracker: valid/ready plus one
// input transaction (mode and received byte). No dependencies.
interface tkc_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] rx_byte;

   modport source (output valid, output mode, output rx_byte, input ready);
   modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

// ===== src/tkc_rsp_if.sv =====
// Response channel of the terminal key cursor tracker: valid/ready plus one
// result transaction (key, byte, cursor, view, quit). No dependencies.
interface tkc_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  key_code;
   logic [7:0]  plain_value;
   logic [11:0] cursor_col;
   logic [15:0] cursor_row;
   logic [15:0] view_row;
   logic [11:0] view_col;
   logic        quit;

   modport source (output valid, output key_code, output plain_value, output cursor_col,
                   output cursor_row, output view_row, output view_col, output quit,
                   input ready);
   modport sink   (input valid, input key_code, input plain_value, input cursor_col,
                   input cursor_row, input view_row, input view_col, input quit,
                   output ready);
endinterface

// ===== src/tkc_decode.sv =====
// Escape sequence decoder: maps one byte or timeout plus parser state to a
// key code and the next parser state. Depends on tkc_pkg.
module tkc_decode
   import tkc_pkg::*;
(
   input  logic [2:0]     phase,
   input  logic [7:0]     digit,
   input  logic           mode,
   input  logic [7:0]     rx_byte,
   output dec_result_type dec
);

   always_comb begin
      dec = '{key: KEY_NONE, phase: phase, digit: digit};
      if (mode == MODE_TIMEOUT) begin
         // Timeout flushes a partial sequence as a bare escape
         dec.phase = PH_IDLE;
         dec.key   = (phase == PH_IDLE) ? KEY_NONE : KEY_ESC;
      end else begin
         unique case (phase)
            PH_IDLE: begin
               if (rx_byte == CH_ESC) begin
                  dec.phase = PH_ESC;
               end else if (rx_byte == CH_CTRL_Q) begin
                  dec.key = KEY_QUIT;
               end else begin
                  dec.key = KEY_PLAIN;
               end
            end
            PH_ESC: begin
               if (rx_byte == CH_LBRACKET) begin
                  dec.phase = PH_BRACKET;
               end else if (rx_byte == CH_UPPER_O) begin
                  dec.phase = PH_OH;
               end else begin
                  dec.phase = PH_OTHER;
               end
            end
            PH_BRACKET: begin
               if (rx_byte >= CH_0 && rx_byte <= CH_9) begin
                  dec.digit = rx_byte;
                  dec.phase = PH_DIGIT;
               end else begin
                  dec.phase = PH_IDLE;
                  case (rx_byte)
                     CH_A:    dec.key = KEY_UP;
                     CH_B:    dec.key = KEY_DOWN;
                     CH_C:    dec.key = KEY_RIGHT;
                     CH_D:    dec.key = KEY_LEFT;
                     CH_H:    dec.key = KEY_HOME;
                     CH_F:    dec.key = KEY_END;
                     default: dec.key = KEY_ESC;
                  endcase
               end
            end
            PH_OH: begin
               dec.phase = PH_IDLE;
               if (rx_byte == CH_H) begin
                  dec.key = KEY_HOME;
               end else if (rx_byte == CH_F) begin
                  dec.key = KEY_END;
               end else begin
                  dec.key = KEY_ESC;
               end
            end
            PH_DIGIT: begin
               dec.phase = PH_IDLE;
               if (rx_byte != CH_TILDE) begin
                  dec.key = KEY_ESC;
               end else begin
                  case (digit) inside
                     CH_1, CH_7: dec.key = KEY_HOME;
                     CH_3:       dec.key = KEY_DEL;
                     CH_4, CH_8: dec.key = KEY_END;
                     CH_5:       dec.key = KEY_PGUP;
                     CH_6:       dec.key = KEY_PGDN;
                     default:    dec.key = KEY_ESC;
                  endcase
               end
            end
            default: begin
               // Escape plus an unknown byte, then one more byte
               dec.phase = PH_IDLE;
               dec.key   = KEY_ESC;
            end
         endcase
      end
   end

endmodule

// ===== src/tkc_motion.sv =====
// Cursor motion and view follow: applies a decoded key to the cursor, then
// slides the view offsets so the cursor stays visible. Depends on tkc_pkg.
module tkc_motion
   import tkc_pkg::*;
(
   input  logic [3:0] key,
   input  geom_type   geom,
   input  pos_type    cur,
   output pos_type    nxt
);

   logic [ROW_W:0]   row_sum;
   logic [COL_W-1:0] col_n;
   logic [ROW_W-1:0] row_n;
   logic [SCR_W-1:0] sr_eff;
   logic [SCR_W-1:0] sc_eff;
   logic [ROW_W-1:0] roff1;
   logic [COL_W-1:0] coff1;
   logic [ROW_W:0]   rbound;
   logic [COL_W:0]   cbound;

   // Move the cursor
   always_comb begin
      col_n   = cur.col;
      row_n   = cur.row;
      row_sum = {1'b0, cur.row} + {{(ROW_W+1-SCR_W){1'b0}}, geom.screen_rows};
      case (key)
         KEY_LEFT:  if (cur.col != '0) col_n = cur.col - 1'b1;
         KEY_RIGHT: if (cur.col != '1) col_n = cur.col + 1'b1;
         KEY_UP:    if (cur.row != '0) row_n = cur.row - 1'b1;
         KEY_DOWN:  if (cur.row < geom.file_rows) row_n = cur.row + 1'b1;
         KEY_HOME:  col_n = '0;
         KEY_END:   col_n = (geom.screen_cols == '0) ? '0 : geom.screen_cols - 1'b1;
         KEY_PGUP: begin
            row_n = (cur.row >= {{(ROW_W-SCR_W){1'b0}}, geom.screen_rows})
                    ? cur.row - {{(ROW_W-SCR_W){1'b0}}, geom.screen_rows} : '0;
         end
         KEY_PGDN: begin
            if (cur.row < geom.file_rows) begin
               row_n = (row_sum > {1'b0, geom.file_rows}) ? geom.file_rows
                                                          : row_sum[ROW_W-1:0];
            end
         end
         default: ;
      endcase
   end

   // Follow the cursor with the view window
   always_comb begin
      sr_eff = (geom.screen_rows == '0) ? SCR_W'(1) : geom.screen_rows;
      sc_eff = (geom.screen_cols == '0) ? SCR_W'(1) : geom.screen_cols;

      roff1  = (row_n < cur.row_off) ? row_n : cur.row_off;
      rbound = {1'b0, roff1} + {{(ROW_W+1-SCR_W){1'b0}}, sr_eff};
      nxt.row_off = ({1'b0, row_n} >= rbound)
                    ? row_n - ({{(ROW_W-SCR_W){1'b0}}, sr_eff} - 1'b1) : roff1;

      coff1  = (col_n < cur.col_off) ? col_n : cur.col_off;
      cbound = {1'b0, coff1} + {1'b0, sc_eff};
      nxt.col_off = ({1'b0, col_n} >= cbound) ? col_n - (sc_eff - 1'b1) : coff1;

      nxt.col = col_n;
      nxt.row = row_n;
   end

endmodule

// ===== src/terminal_key_cursor_tracker.sv =====
// Top level of the terminal key cursor tracker: parser and cursor state,
// configuration registers and the result register. Depends on tkc_pkg,
// tkc_req_if, tkc_rsp_if, tkc_decode and tkc_motion.
//
// Takes one transaction per clock while results are drained: each received byte
// or timeout is decoded, applied to the cursor and view, and its result appears
// in the response register on the next clock edge. The request side stays ready
// whenever the response register is empty or being drained in the same cycle,
// so the sustained rate is one transaction per cycle while the receiver keeps up.
// Configuration writes take effect on the next transaction.
module terminal_key_cursor_tracker
   import tkc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   tkc_req_if.sink               req_chan,
   tkc_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   geom_type       geom_ff;
   logic [2:0]     phase_ff, phase_in;
   logic [7:0]     digit_ff, digit_in;
   pos_type        pos_ff, pos_in;
   logic           halted_ff, halted_in;
   logic           rsp_valid_ff;
   logic [3:0]     key_ff, key_in;
   logic [7:0]     plain_ff, plain_in;

   dec_result_type dec;
   pos_type        moved;
   logic           accept;

   // Accept while the result register is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   tkc_decode u_decode (
      .phase   (phase_ff),
      .digit   (digit_ff),
      .mode    (req_chan.mode),
      .rx_byte (req_chan.rx_byte),
      .dec     (dec)
   );

   tkc_motion u_motion (
      .key  (dec.key),
      .geom (geom_ff),
      .cur  (pos_ff),
      .nxt  (moved)
   );

   // Build next state; hold everything once quit has latched
   always_comb begin
      phase_in  = phase_ff;
      digit_in  = digit_ff;
      pos_in    = pos_ff;
      halted_in = halted_ff;
      key_in    = KEY_NONE;
      plain_in  = '0;
      if (!halted_ff) begin
         phase_in = dec.phase;
         digit_in = dec.digit;
         pos_in   = moved;
         key_in   = dec.key;
         if (dec.key == KEY_PLAIN) begin
            plain_in = req_chan.rx_byte;
         end
         if (dec.key == KEY_QUIT) begin
            halted_in = 1'b1;
         end
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff <= '{screen_rows: SCREEN_ROWS_RST, screen_cols: SCREEN_COLS_RST,
                      file_rows: FILE_ROWS_RST};
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SCREEN_ROWS: geom_ff.screen_rows <= csr_wdata[SCR_W-1:0];
            CSR_SCREEN_COLS: geom_ff.screen_cols <= csr_wdata[SCR_W-1:0];
            CSR_FILE_ROWS:   geom_ff.file_rows   <= csr_wdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance parser and cursor state on each transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         digit_ff  <= '0;
         pos_ff    <= '0;
         halted_ff <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         digit_ff  <= digit_in;
         pos_ff    <= pos_in;
         halted_ff <= halted_in;
      end
   end

   // Result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff   <= key_in;
         plain_ff <= plain_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.key_code    = key_ff;
   assign rsp_chan.plain_value = plain_ff;
   assign rsp_chan.cursor_col  = pos_ff.col;
   assign rsp_chan.cursor_row  = pos_ff.row;
   assign rsp_chan.view_row    = pos_ff.row_off;
   assign rsp_chan.view_col    = pos_ff.col_off;
   assign rsp_chan.quit        = halted_ff;

endmodule

// ===== sim/terminal_key_cursor_tracker_test.sv =====
// Self-checking testbench for the terminal key cursor tracker.
// Depends on tkc_pkg, the tkc_req_if and tkc_rsp_if interfaces and the
// terminal_key_cursor_tracker top level with its tkc_decode and tkc_motion parts.
module terminal_key_cursor_tracker_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tkc_pkg::*;

   localparam int unsigned COL_LIMIT   = 4095;
   localparam int unsigned ROW_LIMIT   = 65535;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          PHASE_ITEMS = 225;
   localparam int          NUM_PHASES  = 8;

   // One input transaction: a byte or a read timeout
   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
   } key_in_type;

   // One result transaction: decoded key plus cursor and view
   typedef struct packed {
      logic [3:0]       key_code;
      logic [7:0]       plain_value;
      logic [COL_W-1:0] cursor_col;
      logic [ROW_W-1:0] cursor_row;
      logic [ROW_W-1:0] view_row;
      logic [COL_W-1:0] view_col;
      logic             quit;
   } cursor_report_type;

   // Directed row; a typed row carries its key and byte, cursor and view are zero
   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
      logic       typed;
      logic [3:0] key_code;
      logic [7:0] plain_value;
   } stim_row_type;

   // Window setting for one random phase, with a bias toward page down
   typedef struct packed {
      logic [SCR_W-1:0] rows;
      logic [SCR_W-1:0] cols;
      logic [ROW_W-1:0] file;
      logic [6:0]       pgdn_bias;
   } window_setting_type;

   localparam stim_row_type DIRECTED_ROWS [29] = '{
      // timeout while idle, then byte extremes
      '{MODE_TIMEOUT, 8'h00, 1'b1, KEY_NONE, 8'h00},
      '{MODE_BYTE, 8'h00, 1'b1, KEY_PLAIN, 8'h00},
      '{MODE_BYTE, 8'hff, 1'b1, KEY_PLAIN, 8'hff},
      // timeout in mid-sequence
      '{MODE_BYTE, CH_ESC, 1'b1, KEY_NONE, 8'h00},
      '{MODE_TIMEOUT, 8'ha5, 1'b1, KEY_ESC, 8'h00},
      // unknown sequence: ESC and two other bytes
      '{MODE_BYTE, CH_ESC, 1'b1, KEY_NONE, 8'h00},
      '{MODE_BYTE, 8'h78, 1'b1, KEY_NONE, 8'h00},
      '{MODE_BYTE, 8'h79, 1'b1, KEY_ESC, 8'h00},
      // Ctrl-Q inside a sequence is a sequence byte
      '{MODE_BYTE, CH_ESC, 1'b1, KEY_NONE, 8'h00},
      '{MODE_BYTE, CH_LBRACKET, 1'b1, KEY_NONE, 8'h00},
      '{MODE_BYTE, CH_CTRL_Q, 1'b1, KEY_ESC, 8'h00},
      // up while at the top row
      '{MODE_BYTE, CH_ESC, 1'b1, KEY_NONE, 8'h00},
      '{MODE_BYTE, CH_LBRACKET, 1'b1, KEY_NONE, 8'h00},
      '{MODE_BYTE, CH_A, 1'b1, KEY_UP, 8'h00},
      // unmatched digit
      '{MODE_BYTE, CH_ESC, 1'b1, KEY_NONE, 8'h00},
      '{MODE_BYTE, CH_LBRACKET, 1'b1, KEY_NONE, 8'h00},
      '{MODE_BYTE, CH_9, 1'b1, KEY_NONE, 8'h00},
      '{MODE_BYTE, CH_TILDE, 1'b1, KEY_ESC, 8'h00},
      // end through the O form
      '{MODE_BYTE, CH_ESC, 1'b0, KEY_NONE, 8'h00},
      '{MODE_BYTE, CH_UPPER_O, 1'b0, KEY_NONE, 8'h00},
      '{MODE_BYTE, CH_F, 1'b0, KEY_NONE, 8'h00},
      // delete
      '{MODE_BYTE, CH_ESC, 1'b0, KEY_NONE, 8'h00},
      '{MODE_BYTE, CH_LBRACKET, 1'b0, KEY_NONE, 8'h00},
      '{MODE_BYTE, CH_3, 1'b0, KEY_NONE, 8'h00},
      '{MODE_BYTE, CH_TILDE, 1'b0, KEY_NONE, 8'h00},
      // page down with an empty file
      '{MODE_BYTE, CH_ESC, 1'b0, KEY_NONE, 8'h00},
      '{MODE_BYTE, CH_LBRACKET, 1'b0, KEY_NONE, 8'h00},
      '{MODE_BYTE, CH_6, 1'b0, KEY_NONE, 8'h00},
      '{MODE_BYTE, CH_TILDE, 1'b0, KEY_NONE, 8'h00}
   };

   localparam window_setting_type WINDOW_SETTINGS [NUM_PHASES] = '{
      '{12'd24, 12'd80, 16'd200, 7'd20},
      '{12'd1, 12'd1, 16'd65535, 7'd30},
      '{12'd4095, 12'd4095, 16'd65535, 7'd40},
      '{12'd0, 12'd0, 16'd50, 7'd0},
      '{12'd3, 12'd5, 16'd40, 7'd10},
      '{12'd7, 12'd12, 16'd0, 7'd10},
      '{12'd4095, 12'd1, 16'd1000, 7'd15},
      '{12'd2, 12'd4095, 16'd9, 7'd5}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tkc_req_if key_req ();
   tkc_rsp_if key_rsp ();

   terminal_key_cursor_tracker i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (key_req),
      .rsp_chan  (key_rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted tracker state and window registers
   logic [2:0]       trk_phase     = PH_IDLE;
   logic [7:0]       trk_digit     = 8'h00;
   logic [COL_W-1:0] trk_col       = '0;
   logic [ROW_W-1:0] trk_row       = '0;
   logic [ROW_W-1:0] trk_view_row  = '0;
   logic [COL_W-1:0] trk_view_col  = '0;
   logic             trk_halted    = 1'b0;
   logic [SCR_W-1:0] win_rows      = SCREEN_ROWS_RST;
   logic [SCR_W-1:0] win_cols      = SCREEN_COLS_RST;
   logic [ROW_W-1:0] win_file_rows = FILE_ROWS_RST;

   cursor_report_type awaited_reports [$];
   key_in_type        key_bytes_due [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int fail_count     = 0;
   int item_count     = 0;
   int report_count   = 0;
   int cycle_count    = 0;

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run the escape parser one step; return the decoded key
   function automatic logic [3:0] decode_key(input logic mode, input logic [7:0] b);
      logic [2:0] was;
      was = trk_phase;
      if (mode == MODE_TIMEOUT) begin
         trk_phase = PH_IDLE;
         return (was == PH_IDLE) ? KEY_NONE : KEY_ESC;
      end
      case (was)
         PH_IDLE: begin
            if (b == CH_ESC) begin
               trk_phase = PH_ESC;
               return KEY_NONE;
            end
            return (b == CH_CTRL_Q) ? KEY_QUIT : KEY_PLAIN;
         end
         PH_ESC: begin
            trk_phase = (b == CH_LBRACKET) ? PH_BRACKET :
                        (b == CH_UPPER_O)  ? PH_OH : PH_OTHER;
            return KEY_NONE;
         end
         PH_BRACKET: begin
            if (b >= CH_0 && b <= CH_9) begin
               trk_digit = b;
               trk_phase = PH_DIGIT;
               return KEY_NONE;
            end
            trk_phase = PH_IDLE;
            case (b)
               CH_A:    return KEY_UP;
               CH_B:    return KEY_DOWN;
               CH_C:    return KEY_RIGHT;
               CH_D:    return KEY_LEFT;
               CH_H:    return KEY_HOME;
               CH_F:    return KEY_END;
               default: return KEY_ESC;
            endcase
         end
         PH_OH: begin
            trk_phase = PH_IDLE;
            if (b == CH_H) return KEY_HOME;
            if (b == CH_F) return KEY_END;
            return KEY_ESC;
         end
         PH_DIGIT: begin
            trk_phase = PH_IDLE;
            if (b != CH_TILDE) return KEY_ESC;
            case (trk_digit)
               CH_1, CH_7: return KEY_HOME;
               CH_3:       return KEY_DEL;
               CH_4, CH_8: return KEY_END;
               CH_5:       return KEY_PGUP;
               CH_6:       return KEY_PGDN;
               default:    return KEY_ESC;
            endcase
         end
         default: begin
            trk_phase = PH_IDLE;
            return KEY_ESC;
         end
      endcase
   endfunction

   // Apply one transaction to the predicted tracker and build its report
   function automatic cursor_report_type advance_cursor_tracker(input logic mode,
                                                                input logic [7:0] b);
      cursor_report_type rep;
      logic [3:0]        key;
      int unsigned       col, row, vrow, vcol, sr, sc, lim;
      rep = '0;
      key = KEY_NONE;
      if (!trk_halted) begin
         key  = decode_key(mode, b);
         col  = trk_col;
         row  = trk_row;
         vrow = trk_view_row;
         vcol = trk_view_col;
         lim  = (win_file_rows < ROW_LIMIT) ? win_file_rows : ROW_LIMIT;
         case (key)
            KEY_PLAIN: rep.plain_value = b;
            KEY_QUIT:  trk_halted = 1'b1;
            KEY_LEFT:  if (col != 0) col = col - 1;
            KEY_RIGHT: if (col < COL_LIMIT) col = col + 1;
            KEY_UP:    if (row != 0) row = row - 1;
            KEY_DOWN:  if (row < win_file_rows && row < ROW_LIMIT) row = row + 1;
            KEY_HOME:  col = 0;
            KEY_END: begin
               col = (win_cols == 0) ? 0 : win_cols - 1;
               if (col > COL_LIMIT) col = COL_LIMIT;
            end
            KEY_PGUP:  row = (row >= win_rows) ? row - win_rows : 0;
            KEY_PGDN: begin
               if (row < lim) begin
                  row = row + win_rows;
                  if (row > lim) row = lim;
               end
            end
            default: ;
         endcase
         // keep the cursor inside the window; a zero size scrolls as one
         sr = (win_rows == 0) ? 1 : win_rows;
         sc = (win_cols == 0) ? 1 : win_cols;
         if (row < vrow) vrow = row;
         if (row >= vrow + sr) vrow = row - sr + 1;
         if (col < vcol) vcol = col;
         if (col >= vcol + sc) vcol = col - sc + 1;
         trk_col      = COL_W'(col);
         trk_row      = ROW_W'(row);
         trk_view_row = ROW_W'(vrow);
         trk_view_col = COL_W'(vcol);
      end
      rep.key_code   = key;
      rep.cursor_col = trk_col;
      rep.cursor_row = trk_row;
      rep.view_row   = trk_view_row;
      rep.view_col   = trk_view_col;
      rep.quit       = trk_halted;
      return rep;
   endfunction

   function automatic void push_byte(input logic [7:0] b);
      key_in_type item;
      item.mode    = MODE_BYTE;
      item.rx_byte = b;
      key_bytes_due.push_back(item);
   endfunction

   function automatic void push_timeout();
      key_in_type item;
      item.mode    = MODE_TIMEOUT;
      item.rx_byte = 8'($urandom);
      key_bytes_due.push_back(item);
   endfunction

   // Queue one random burst: mostly well-formed key sequences, some noise
   function automatic void queue_key_burst(input int pgdn_bias);
      int         pick;
      int         form;
      logic [7:0] tail;
      pick = $urandom_range(99);
      if (pick < 65) begin
         form = ($urandom_range(99) < pgdn_bias) ? 12 : $urandom_range(14);
         push_byte(CH_ESC);
         if (form < 6) begin
            push_byte(CH_LBRACKET);
            case (form)
               0:       push_byte(CH_A);
               1:       push_byte(CH_B);
               2:       push_byte(CH_C);
               3:       push_byte(CH_D);
               4:       push_byte(CH_H);
               default: push_byte(CH_F);
            endcase
         end else if (form < 8) begin
            push_byte(CH_UPPER_O);
            push_byte((form == 6) ? CH_H : CH_F);
         end else begin
            push_byte(CH_LBRACKET);
            case (form)
               8:       push_byte(CH_1);
               9:       push_byte(CH_3);
               10:      push_byte(CH_4);
               11:      push_byte(CH_5);
               12:      push_byte(CH_6);
               13:      push_byte(CH_7);
               default: push_byte(CH_8);
            endcase
            push_byte(CH_TILDE);
         end
      end else if (pick < 78) begin
         push_byte(8'($urandom));
      end else if (pick < 86) begin
         push_timeout();
      end else begin
         // mostly broken sequence: a valid prefix, then a tilde, a random byte or a timeout
         push_byte(CH_ESC);
         case ($urandom_range(3))
            0: push_byte(8'($urandom));
            1: push_byte(CH_LBRACKET);
            2: begin
               push_byte(CH_LBRACKET);
               push_byte(CH_0 + 8'($urandom_range(9)));
            end
            default: push_byte(CH_UPPER_O);
         endcase
         tail = $urandom_range(1) ? CH_TILDE : 8'($urandom);
         if ($urandom_range(2) == 0) push_timeout();
         else push_byte(tail);
      end
   endfunction

   // Offer one transaction, wait for the handshake, record its expected report
   task automatic send_key(input key_in_type item, input logic typed,
                           input cursor_report_type typed_rep);
      cursor_report_type rep;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         key_req.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      key_req.valid   <= 1'b1;
      key_req.mode    <= item.mode;
      key_req.rx_byte <= item.rx_byte;
      do @(posedge clock); while (!key_req.ready);
      rep = advance_cursor_tracker(item.mode, item.rx_byte);
      awaited_reports.push_back(typed ? typed_rep : rep);
      item_count++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every report is back
   task automatic drain_reports();
      key_req.valid <= 1'b0;
      while (awaited_reports.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // Write all three window registers while the block is idle
   task automatic write_window(input window_setting_type ws);
      csr_we    <= 1'b1;
      csr_index <= CSR_SCREEN_ROWS;
      csr_wdata <= CSR_DATA_W'(ws.rows);
      @(negedge clock);
      csr_index <= CSR_SCREEN_COLS;
      csr_wdata <= CSR_DATA_W'(ws.cols);
      @(negedge clock);
      csr_index <= CSR_FILE_ROWS;
      csr_wdata <= ws.file;
      @(negedge clock);
      csr_we        <= 1'b0;
      win_rows      = ws.rows;
      win_cols      = ws.cols;
      win_file_rows = ws.file;
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Receiver pacing
   always @(negedge clock)
      key_rsp.ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);

   // Compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      cursor_report_type want;
      if (!reset && key_rsp.valid && key_rsp.ready) begin
         if (awaited_reports.size() == 0) begin
            $error("result transaction with nothing expected");
            fail_count++;
         end else begin
            want = awaited_reports.pop_front();
            report_count++;
            check_field("key_code", want.key_code, key_rsp.key_code);
            check_field("plain_value", want.plain_value, key_rsp.plain_value);
            check_field("cursor_col", want.cursor_col, key_rsp.cursor_col);
            check_field("cursor_row", want.cursor_row, key_rsp.cursor_row);
            check_field("view_row", want.view_row, key_rsp.view_row);
            check_field("view_col", want.view_col, key_rsp.view_col);
            check_field("quit", want.quit, key_rsp.quit);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("run did not finish within %0d cycles", CYCLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      key_in_type        item;
      cursor_report_type typed_rep;
      int                sent;
      int                ignored;

      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = CSR_SCREEN_ROWS;
      csr_wdata       = '0;
      key_req.valid   = 1'b0;
      key_req.mode    = MODE_BYTE;
      key_req.rx_byte = 8'h00;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed table under the reset window
      foreach (DIRECTED_ROWS[i]) begin
         item.mode             = DIRECTED_ROWS[i].mode;
         item.rx_byte          = DIRECTED_ROWS[i].rx_byte;
         typed_rep             = '0;
         typed_rep.key_code    = DIRECTED_ROWS[i].key_code;
         typed_rep.plain_value = DIRECTED_ROWS[i].plain_value;
         send_key(item, DIRECTED_ROWS[i].typed, typed_rep);
      end

      // Random phases: each with a new window and a new pacing mode
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_reports();
         write_window(WINDOW_SETTINGS[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 21; recv_stall_pct = 21; end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if (key_bytes_due.size() == 0) queue_key_burst(WINDOW_SETTINGS[p].pgdn_bias);
            item = key_bytes_due.pop_front();
            // hold quit back until the closing part
            if (item.mode == MODE_BYTE && trk_phase == PH_IDLE && item.rx_byte == CH_CTRL_Q)
               item.rx_byte = item.rx_byte ^ 8'h80;
            send_key(item, 1'b0, '0);
            sent++;
         end
      end

      // Latch quit from a clean parser, then show that input is ignored
      item.mode    = MODE_TIMEOUT;
      item.rx_byte = 8'h00;
      send_key(item, 1'b0, '0);
      item.mode    = MODE_BYTE;
      item.rx_byte = CH_CTRL_Q;
      send_key(item, 1'b0, '0);
      for (ignored = 0; ignored < 12; ignored++) begin
         item.mode    = ($urandom_range(3) == 0) ? MODE_TIMEOUT : MODE_BYTE;
         item.rx_byte = 8'($urandom);
         send_key(item, 1'b0, '0);
      end

      drain_reports();
      $display("Checked %0d results from %0d transactions across %0d window settings,",
               report_count, item_count, NUM_PHASES);
      $display("with four pacing modes and a closing stretch after quit.");
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
